### rtl/core/nsrt_pkg.sv
package nsrt_pkg;

  localparam int SLOTS_DEFAULT      = 16;
  localparam int NAME_BYTES_DEFAULT = 8;
  localparam int REF_BITS_DEFAULT   = 8;

  localparam int NAME_W   = 64;
  localparam int COUNT_W  = 16;
  localparam int SIDX_W   = 4;
  localparam int STATUS_W = 3;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 24;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_JOINED   = 3'd0;
  localparam status_t ST_CREATED  = 3'd1;
  localparam status_t ST_MISMATCH = 3'd2;
  localparam status_t ST_ABSENT   = 3'd3;
  localparam status_t ST_FULL     = 3'd4;
  localparam status_t ST_OVERFLOW = 3'd5;
  localparam status_t ST_FREED    = 3'd6;
  localparam status_t ST_IGNORED  = 3'd7;

  localparam logic REQ_OPEN = 1'b0;
  localparam logic REQ_FREE = 1'b1;

endpackage

### rtl/core/named_semaphore_refcount_table_core.sv
// Table of SLOTS named semaphore slots, each holding a name key, a reference
// count and a maximum count. One request is worked at a time: s_tready is high
// only while the block is idle. An open scans the slot memory one slot at a time
// (registered read state, then name compare state) and stops at the first live
// match or after the last slot; a free reads its slot, then writes it back. The
// scan speed is set by the single read port of the slot memory and the one name
// comparator shared by the scan. A finished result waits
// in the output register, and the next request may be accepted meanwhile.
module named_semaphore_refcount_table_core #(
  parameter int SLOTS      = nsrt_pkg::SLOTS_DEFAULT,
  parameter int NAME_BYTES = nsrt_pkg::NAME_BYTES_DEFAULT,
  parameter int REF_BITS   = nsrt_pkg::REF_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // name_key[63:0], count_known[64], initial_count[80:65], slot_index[84:81]
  input  logic [nsrt_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // granted[0], slot[4:1], max_count[20:5], slot_released[21]
  output logic [nsrt_pkg::M_TDATA_W-1:0] m_tdata,
  // status[2:0]
  output nsrt_pkg::status_t              m_tuser
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FREE_RD  = 3'd1;
  localparam logic [2:0] S_FREE_WR  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CMP = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state;

  logic [nsrt_pkg::NAME_W-1:0]  name_mem [SLOTS];
  logic [nsrt_pkg::COUNT_W-1:0] max_mem  [SLOTS];
  logic [REF_BITS-1:0]          cnt_mem  [SLOTS];
  logic [SLOTS-1:0]             live;

  logic [nsrt_pkg::NAME_W-1:0]  rd_name;
  logic [nsrt_pkg::COUNT_W-1:0] rd_max;
  logic [REF_BITS-1:0]          rd_cnt;

  logic [IDX_W-1:0]             idx;
  logic [nsrt_pkg::NAME_W-1:0]  req_key;
  logic                         req_known;
  logic [nsrt_pkg::COUNT_W-1:0] req_count;
  logic                         req_in_range;
  logic                         have_free;
  logic [IDX_W-1:0]             free_idx;

  nsrt_pkg::status_t            res_status;
  logic                         res_granted;
  logic [nsrt_pkg::SIDX_W-1:0]  res_slot;
  logic [nsrt_pkg::COUNT_W-1:0] res_max;
  logic                         res_released;

  logic [nsrt_pkg::NAME_W-1:0]  in_key;
  logic [nsrt_pkg::COUNT_W-1:0] in_count;
  logic [nsrt_pkg::SIDX_W-1:0]  in_slot;
  logic [nsrt_pkg::NAME_W-1:0]  norm_key;

  logic                         we_ent;
  logic                         we_cnt;
  logic [IDX_W-1:0]             waddr;
  logic [REF_BITS-1:0]          wcnt;

  logic                         name_hit;
  logic                         slot_free;
  logic [IDX_W-1:0]             create_idx;
  logic                         can_create;
  logic                         free_ok;

  assign in_key   = s_tdata[63:0];
  assign in_count = s_tdata[80:65];
  assign in_slot  = s_tdata[84:81];

  // name ends at the first zero byte or after NAME_BYTES bytes
  always_comb begin
    logic alive;
    alive = 1'b1;
    norm_key = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= NAME_BYTES || in_key[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      norm_key[8*b +: 8] = alive ? in_key[8*b +: 8] : 8'd0;
    end
  end

  assign s_tready   = (state == S_IDLE);
  assign name_hit   = live[idx] && (rd_name == req_key);
  assign slot_free  = !live[idx];
  assign create_idx = have_free ? free_idx : idx;
  assign can_create = have_free || slot_free;
  assign free_ok    = req_in_range && live[idx];

  always_comb begin
    we_ent = 1'b0;
    we_cnt = 1'b0;
    waddr  = idx;
    wcnt   = rd_cnt + REF_BITS'(1);
    case (state)
      S_FREE_WR: begin
        we_cnt = free_ok;
        wcnt   = rd_cnt - REF_BITS'(1);
      end
      S_SCAN_CMP: begin
        if (name_hit) begin
          we_cnt = !(req_known && rd_max != req_count) && !(&rd_cnt);
        end else if (idx == LAST_IDX && req_known && can_create) begin
          we_ent = 1'b1;
          we_cnt = 1'b1;
          waddr  = create_idx;
          wcnt   = REF_BITS'(1);
        end
      end
      default: begin
        we_cnt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_ent) begin
      name_mem[waddr] <= req_key;
      max_mem[waddr]  <= req_count;
    end
    if (we_cnt) begin
      cnt_mem[waddr] <= wcnt;
    end
    rd_name <= name_mem[idx];
    rd_max  <= max_mem[idx];
    rd_cnt  <= cnt_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      live     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_key      <= norm_key;
            req_known    <= s_tdata[64];
            req_count    <= in_count;
            req_in_range <= (9'(in_slot) < 9'(SLOTS));
            have_free    <= 1'b0;
            free_idx     <= '0;
            res_status   <= nsrt_pkg::ST_IGNORED;
            res_granted  <= 1'b0;
            res_slot     <= '0;
            res_max      <= '0;
            res_released <= 1'b0;
            if (s_tuser == nsrt_pkg::REQ_FREE) begin
              idx   <= IDX_W'(in_slot);
              state <= S_FREE_RD;
            end else begin
              idx   <= '0;
              state <= S_SCAN_RD;
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          if (free_ok) begin
            res_status <= nsrt_pkg::ST_FREED;
            res_slot   <= nsrt_pkg::SIDX_W'(idx);
            if (rd_cnt == REF_BITS'(1)) begin
              res_released <= 1'b1;
              live[idx]    <= 1'b0;
            end
          end
          state <= S_DONE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (slot_free && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
          if (name_hit) begin
            if (req_known && rd_max != req_count) begin
              res_status <= nsrt_pkg::ST_MISMATCH;
            end else if (&rd_cnt) begin
              res_status <= nsrt_pkg::ST_OVERFLOW;
            end else begin
              res_status  <= nsrt_pkg::ST_JOINED;
              res_granted <= 1'b1;
              res_slot    <= nsrt_pkg::SIDX_W'(idx);
              res_max     <= rd_max;
            end
            state <= S_DONE;
          end else if (idx == LAST_IDX) begin
            if (!req_known) begin
              res_status <= nsrt_pkg::ST_ABSENT;
            end else if (can_create) begin
              res_status       <= nsrt_pkg::ST_CREATED;
              res_granted      <= 1'b1;
              res_slot         <= nsrt_pkg::SIDX_W'(create_idx);
              res_max          <= req_count;
              live[create_idx] <= 1'b1;
            end else begin
              res_status <= nsrt_pkg::ST_FULL;
            end
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, res_released, res_max, res_slot, res_granted};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/nsrt_checker.sv
module nsrt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [nsrt_pkg::M_TDATA_W-1:0] m_tdata,
  input nsrt_pkg::status_t              m_tuser
);

  logic in_item;
  logic granted_code;

  assign in_item      = s_tvalid && s_tready;
  assign granted_code = (m_tuser == nsrt_pkg::ST_JOINED) || (m_tuser == nsrt_pkg::ST_CREATED);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_item |=> !s_tready)
    else $error("ready right after an accepted item");

  a_granted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == granted_code))
    else $error("granted flag disagrees with status");

  a_released: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> (m_tuser == nsrt_pkg::ST_FREED))
    else $error("release reported outside a free");

  a_no_grant_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !granted_code |-> (m_tdata[20:5] == 16'd0))
    else $error("max count set without a grant");

endmodule

bind named_semaphore_refcount_table_core nsrt_checker u_nsrt_checker (.*);

### verif/named_semaphore_refcount_table_core_tb.sv
module named_semaphore_refcount_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = nsrt_pkg::SLOTS_DEFAULT;
  localparam int REF_MAX = (1 << nsrt_pkg::REF_BITS_DEFAULT) - 1;
  localparam int PLAN = 0;
  localparam int MODEL = 1;
  localparam int POOL = 24;
  localparam int ITEMS = 1350;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 200;
  localparam int TAIL = 80;

  typedef struct packed {
    logic        req_type;
    logic [63:0] name_key;
    logic        count_known;
    logic [15:0] initial_count;
    logic [3:0]  slot_index;
  } request_t;

  typedef struct packed {
    nsrt_pkg::status_t status;
    logic              granted;
    logic [3:0]        slot;
    logic [15:0]       max_count;
    logic              released;
  } answer_t;

  typedef struct packed {
    request_t req;
    logic     wait_idle;
  } queued_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [nsrt_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [nsrt_pkg::M_TDATA_W-1:0] m_tdata;
  nsrt_pkg::status_t              m_tuser;

  // slot tables: one for the stimulus planner, one for checking
  logic [63:0] slot_key  [2][SLOTS];
  int          slot_refs [2][SLOTS];
  logic [15:0] slot_max  [2][SLOTS];

  queued_t request_q[$];
  answer_t answer_q[$];

  logic [63:0] pool_key [POOL];
  logic [15:0] pool_cnt [POOL];

  int planned = 0;
  int acc_cnt = 0;
  int res_cnt = 0;
  int errors = 0;
  int stall_cycles = 0;
  bit pause_next = 1'b0;

  int tx_taken = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_seen = 0;
  int rx_wait = 0;
  int rx_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  named_semaphore_refcount_table_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] norm_name(input logic [63:0] raw);
    logic [63:0] key;
    bit stop;
    key = '0;
    stop = 1'b0;
    for (int b = 0; b < nsrt_pkg::NAME_BYTES_DEFAULT; b++) begin
      if (raw[8*b +: 8] == 8'h00) stop = 1'b1;
      if (!stop) key[8*b +: 8] = raw[8*b +: 8];
    end
    return key;
  endfunction

  function automatic answer_t serve(input int tb, input request_t r);
    answer_t a;
    logic [63:0] key;
    bit done;
    int idx;
    a.status = nsrt_pkg::ST_IGNORED;
    a.granted = 1'b0;
    a.slot = '0;
    a.max_count = '0;
    a.released = 1'b0;
    if (r.req_type == nsrt_pkg::REQ_OPEN) begin
      key = norm_name(r.name_key);
      done = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && slot_refs[tb][i] != 0 && slot_key[tb][i] == key) begin
          done = 1'b1;
          if (r.count_known && slot_max[tb][i] != r.initial_count) begin
            a.status = nsrt_pkg::ST_MISMATCH;
          end else if (slot_refs[tb][i] >= REF_MAX) begin
            a.status = nsrt_pkg::ST_OVERFLOW;
          end else begin
            slot_refs[tb][i]++;
            a.status = nsrt_pkg::ST_JOINED;
            a.granted = 1'b1;
            a.slot = i[3:0];
            a.max_count = slot_max[tb][i];
          end
        end
      end
      if (!done) begin
        if (!r.count_known) begin
          a.status = nsrt_pkg::ST_ABSENT;
        end else begin
          a.status = nsrt_pkg::ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!done && slot_refs[tb][i] == 0) begin
              done = 1'b1;
              slot_key[tb][i] = key;
              slot_max[tb][i] = r.initial_count;
              slot_refs[tb][i] = 1;
              a.status = nsrt_pkg::ST_CREATED;
              a.granted = 1'b1;
              a.slot = i[3:0];
              a.max_count = r.initial_count;
            end
          end
        end
      end
    end else begin
      idx = int'(r.slot_index);
      if (idx < SLOTS && slot_refs[tb][idx] != 0) begin
        slot_refs[tb][idx]--;
        a.status = nsrt_pkg::ST_FREED;
        a.slot = r.slot_index;
        if (slot_refs[tb][idx] == 0) begin
          a.released = 1'b1;
          slot_key[tb][idx] = '0;
          slot_max[tb][idx] = '0;
        end
      end
    end
    return a;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // put junk after the terminating zero byte
  function automatic logic [63:0] dress(input logic [63:0] base);
    int len;
    logic [63:0] junk;
    len = 8;
    for (int b = 7; b >= 0; b--) begin
      if (base[8*b +: 8] == 8'h00) len = b;
    end
    junk = {$urandom, $urandom};
    if (len <= 6 && $urandom_range(0, 1) == 1) return base | (junk << (8 * (len + 1)));
    return base;
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_refs[PLAN][i] == 0) n++;
    end
    return n;
  endfunction

  task automatic push(input request_t r);
    queued_t q;
    q.req = r;
    q.wait_idle = pause_next;
    pause_next = 1'b0;
    request_q.push_back(q);
    void'(serve(PLAN, r));
    planned++;
  endtask

  task automatic open_item(input logic [63:0] key, input logic known, input logic [15:0] cnt);
    request_t r;
    r.req_type = nsrt_pkg::REQ_OPEN;
    r.name_key = key;
    r.count_known = known;
    r.initial_count = cnt;
    r.slot_index = 4'($urandom_range(0, 15));
    push(r);
  endtask

  task automatic free_item(input int idx);
    request_t r;
    r.req_type = nsrt_pkg::REQ_FREE;
    r.name_key = {$urandom, $urandom};
    r.count_known = 1'($urandom_range(0, 1));
    r.initial_count = 16'($urandom_range(0, 65535));
    r.slot_index = idx[3:0];
    push(r);
  endtask

  task automatic free_all();
    for (int i = 0; i < SLOTS; i++) begin
      while (slot_refs[PLAN][i] > 0) free_item(i);
    end
  endtask

  task automatic report(input string msg);
    $display("error: %s", msg);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    bit waiting;
    if (!rst) begin
      waiting = s_tvalid && (acc_cnt == tx_taken);
      if (s_tvalid && acc_cnt != tx_taken) begin
        tx_taken = acc_cnt;
        tx_gap = draw_wait(tx_calm);
      end
      if (!waiting) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].wait_idle && answer_q.size() > 0)) begin
          s_tdata <= {3'b000, request_q[0].req.slot_index, request_q[0].req.initial_count,
                      request_q[0].req.count_known, request_q[0].req.name_key};
          s_tuser <= request_q[0].req.req_type;
          s_tvalid <= 1'b1;
          void'(request_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready
  always @(negedge clk) begin
    if (!rst) begin
      if (res_cnt != rx_seen) begin
        rx_seen = res_cnt;
        rx_wait = draw_wait(rx_calm);
      end
      if (res_cnt >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    request_t got_req;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        res_cnt++;
        if (answer_q.size() == 0) begin
          report($sformatf("result with nothing expected, status %0d", m_tuser));
        end else begin
          want = answer_q.pop_front();
          if (m_tuser != want.status)
            report($sformatf("status got %0d expected %0d", m_tuser, want.status));
          if (m_tdata[0] != want.granted)
            report($sformatf("granted got %0d expected %0d", m_tdata[0], want.granted));
          if (m_tdata[4:1] != want.slot)
            report($sformatf("slot got %0d expected %0d", m_tdata[4:1], want.slot));
          if (m_tdata[20:5] != want.max_count)
            report($sformatf("max_count got %0h expected %0h", m_tdata[20:5], want.max_count));
          if (m_tdata[21] != want.released)
            report($sformatf("slot_released got %0d expected %0d", m_tdata[21], want.released));
        end
      end
      if (s_tvalid && s_tready) begin
        got_req.req_type = s_tuser;
        got_req.name_key = s_tdata[63:0];
        got_req.count_known = s_tdata[64];
        got_req.initial_count = s_tdata[80:65];
        got_req.slot_index = s_tdata[84:81];
        answer_q.push_back(serve(MODEL, got_req));
        acc_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int len, kind, pick, roll, n_live;
    int live [SLOTS];
    bit piled;
    logic [63:0] key;

    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[t][i] = '0;
        slot_refs[t][i] = 0;
        slot_max[t][i] = '0;
      end
    end
    for (int p = 0; p < POOL; p++) begin
      len = $urandom_range(0, 8);
      pool_key[p] = '0;
      for (int b = 0; b < len; b++) pool_key[p][8*b +: 8] = 8'($urandom_range(1, 255));
      pool_cnt[p] = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    end

    // directed part
    free_item(0);
    open_item(64'h0000_0000_0074_6573, 1'b0, 16'h1234);
    open_item(64'h0, 1'b1, 16'h0000);
    open_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF);
    open_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF);
    open_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'h0001);
    open_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'h0001);
    open_item(64'hDEAD_BEEF_0000_6261, 1'b1, 16'h0005);
    open_item(64'h00FF_0000_0000_6261, 1'b0, 16'h0000);
    open_item(64'h5555_5555_5555_5500, 1'b1, 16'h0000);
    open_item(64'h8000_0000_0000_0000, 1'b0, 16'hFFFF);
    for (int k = 0; k < 4; k++) free_item(0);
    free_item(15);
    open_item(64'h0102_0304_0506_0708, 1'b1, 16'h8000);
    for (int k = 0; k < 3; k++) free_item(1);
    open_item(64'h0000_0000_0000_6261, 1'b1, 16'h0006);

    // random part
    piled = 1'b0;
    pause_next = 1'b1;
    while (planned < ITEMS) begin
      if (!piled && planned >= 450) begin
        // drive one slot's reference count to its ceiling and back
        piled = 1'b1;
        free_all();
        pick = $urandom_range(0, POOL - 1);
        open_item(dress(pool_key[pick]), 1'b1, pool_cnt[pick]);
        for (int k = 0; k < REF_MAX + 1; k++) open_item(dress(pool_key[pick]), 1'b0, 16'h0);
        open_item(dress(pool_key[pick]), 1'b1, pool_cnt[pick]);
        open_item(dress(pool_key[pick]), 1'b1, pool_cnt[pick] + 16'd1);
        for (int k = 0; k < REF_MAX; k++) free_item(0);
      end
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
        while (free_slots() > 0) open_item(dress({$urandom, $urandom}), 1'b1, 16'($urandom));
        open_item(dress({$urandom, $urandom}), 1'b1, 16'($urandom));
        open_item(dress(pool_key[$urandom_range(0, POOL - 1)]), 1'b1, 16'($urandom));
        open_item(dress(pool_key[$urandom_range(0, POOL - 1)]), 1'b0, 16'($urandom));
      end else if (kind == 8) begin
        free_all();
      end else begin
        if (kind == 9) pause_next = 1'b1;
        for (int k = 0; k < 20; k++) begin
          roll = $urandom_range(0, 19);
          if (roll < 9) begin
            pick = $urandom_range(0, POOL - 1);
            key = dress(pool_key[pick]);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: open_item(key, 1'b1, pool_cnt[pick]);
              6: open_item(key, 1'b1, 16'($urandom));
              default: open_item(key, 1'b0, 16'($urandom));
            endcase
          end else if (roll < 19) begin
            n_live = 0;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_refs[PLAN][i] > 0) begin
                live[n_live] = i;
                n_live++;
              end
            end
            if (n_live > 0 && roll < 17) free_item(live[$urandom_range(0, n_live - 1)]);
            else free_item($urandom_range(0, 15));
          end else begin
            open_item({$urandom, $urandom}, 1'($urandom_range(0, 1)), 16'($urandom));
          end
        end
      end
    end

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    while (acc_cnt != planned || answer_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (answer_q.size() != 0) report("expected results left over");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
